// ===== rtl/pbu_pkg.sv =====
`timescale 1ns / 1ps

package pbu_pkg;

    localparam int CH_W       = 13;
    localparam int IN_DATA_W  = 104;  // eight channels, byte aligned already
    localparam int OUT_DATA_W = 56;   // four channels, padded to seven bytes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 4;

    localparam logic [CH_W-1:0] FULL_SCALE = 13'd4096;
    localparam logic [CH_W-1:0] HALF_SCALE = 13'd2048;

    // Register index, taken from paddr[2]
    localparam logic REG_BLEND_MODE = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_REPLACE  = 4'd0,
        MODE_ADD      = 4'd1,
        MODE_SUBTRACT = 4'd2,
        MODE_MULTIPLY = 4'd3,
        MODE_BLEND    = 4'd4,
        MODE_MORPH    = 4'd5,
        MODE_INVERT   = 4'd6,
        MODE_MIN      = 4'd7,
        MODE_MAX      = 4'd8,
        MODE_IGNORE   = 4'd9
    } blend_mode_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } pixel_t;

    // Channel values above full scale are clamped to full scale
    function automatic logic [CH_W-1:0] sat_ch(input logic [CH_W-1:0] v);
        return (v > FULL_SCALE) ? FULL_SCALE : v;
    endfunction

endpackage

// ===== rtl/pixel_blend_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Payload
// ---------+-----------+-------------------------------------------------
// cfg APB  | in/out    | blend_mode at byte address 0 (bits 3:0)
// s_axis   | in        | base r,g,b,a then src r,g,b,a, 13 bits each
// m_axis   | out       | out r,g,b,a, 13 bits each, zero padded to 56 bits
//
// Two register stages: a capture register (inputs clamped to 4096) and a
// result register, with the blend math between them. One transfer per clock
// in and out while m_tready is high; m_tvalid follows the result register.
// rst_n clears both valid bits and sets blend_mode to replace.
// A stall on m_tready holds the result; the capture stage still takes one
// more transfer while it is empty, and s_tready drops once both are full.
module pixel_blend_unit
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pbu_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pbu_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pbu_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // base_red, base_green, base_blue, base_alpha,
    // src_red, src_green, src_blue, src_alpha
    input  logic [pbu_pkg::IN_DATA_W-1:0]    s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_red, out_green, out_blue, out_alpha, 4 zero bits
    output logic [pbu_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int W = pbu_pkg::CH_W;

    logic [pbu_pkg::MODE_W-1:0] mode;

    // Capture stage
    logic            in_valid_reg;
    logic            in_valid_next;
    pbu_pkg::pixel_t base_reg;
    pbu_pkg::pixel_t src_reg;
    pbu_pkg::pixel_t base_next;
    pbu_pkg::pixel_t src_next;

    // Result stage
    logic            out_valid_reg;
    logic            out_valid_next;
    pbu_pkg::pixel_t res_reg;
    pbu_pkg::pixel_t res_next;
    pbu_pkg::pixel_t res_comb;

    logic            out_load;
    logic            in_load;

    pbu_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    // Result register is free when empty or being drained this cycle
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_comb
    begin
        base_next.red   = pbu_pkg::sat_ch(s_tdata[0*W +: W]);
        base_next.green = pbu_pkg::sat_ch(s_tdata[1*W +: W]);
        base_next.blue  = pbu_pkg::sat_ch(s_tdata[2*W +: W]);
        base_next.alpha = pbu_pkg::sat_ch(s_tdata[3*W +: W]);
        src_next.red    = pbu_pkg::sat_ch(s_tdata[4*W +: W]);
        src_next.green  = pbu_pkg::sat_ch(s_tdata[5*W +: W]);
        src_next.blue   = pbu_pkg::sat_ch(s_tdata[6*W +: W]);
        src_next.alpha  = pbu_pkg::sat_ch(s_tdata[7*W +: W]);

        in_valid_next  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
        out_valid_next = out_load ? 1'b1 : ((m_tready) ? 1'b0 : out_valid_reg);
        res_next       = res_comb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            base_reg <= base_next;
            src_reg  <= src_next;
        end
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    // Four channel lanes; src alpha is the weight for blend and invert
    pbu_channel u_ch_red
    (
        .mode     (mode),
        .is_alpha (1'b0),
        .base     (base_reg.red),
        .src      (src_reg.red),
        .weight   (src_reg.alpha),
        .result   (res_comb.red)
    );

    pbu_channel u_ch_green
    (
        .mode     (mode),
        .is_alpha (1'b0),
        .base     (base_reg.green),
        .src      (src_reg.green),
        .weight   (src_reg.alpha),
        .result   (res_comb.green)
    );

    pbu_channel u_ch_blue
    (
        .mode     (mode),
        .is_alpha (1'b0),
        .base     (base_reg.blue),
        .src      (src_reg.blue),
        .weight   (src_reg.alpha),
        .result   (res_comb.blue)
    );

    pbu_channel u_ch_alpha
    (
        .mode     (mode),
        .is_alpha (1'b1),
        .base     (base_reg.alpha),
        .src      (src_reg.alpha),
        .weight   (src_reg.alpha),
        .result   (res_comb.alpha)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(pbu_pkg::OUT_DATA_W - 4*W){1'b0}},
                       res_reg.alpha, res_reg.blue, res_reg.green, res_reg.red};

endmodule

// ===== rtl/pbu_cfg.sv =====
`timescale 1ns / 1ps

module pbu_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pbu_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pbu_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pbu_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [pbu_pkg::MODE_W-1:0]       mode
);

    logic [pbu_pkg::MODE_W-1:0] mode_reg;
    logic [pbu_pkg::MODE_W-1:0] mode_next;
    logic                       wr_en;
    logic                       sel_mode;

    assign pready   = 1'b1;
    assign sel_mode = (paddr[2] == pbu_pkg::REG_BLEND_MODE);
    assign wr_en    = psel && penable && pwrite && pready && sel_mode;

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_en)
        begin
            mode_next = pwdata[pbu_pkg::MODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pbu_pkg::MODE_REPLACE;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign prdata = sel_mode ? {{(pbu_pkg::CFG_DATA_W-pbu_pkg::MODE_W){1'b0}}, mode_reg}
                             : '0;
    assign mode   = mode_reg;

endmodule

// ===== rtl/pbu_channel.sv =====
`timescale 1ns / 1ps

// One channel of the blend: one shared signed multiplier, post-processed
// per mode.
module pbu_channel
(
    input  logic [pbu_pkg::MODE_W-1:0] mode,
    input  logic                       is_alpha,
    input  logic [pbu_pkg::CH_W-1:0]   base,
    input  logic [pbu_pkg::CH_W-1:0]   src,
    input  logic [pbu_pkg::CH_W-1:0]   weight,
    output logic [pbu_pkg::CH_W-1:0]   result
);

    logic signed [13:0] diff;
    logic signed [13:0] op_a;
    logic        [12:0] op_b;
    logic signed [27:0] prod;
    logic signed [27:0] quot;
    logic        [13:0] sum;
    logic        [25:0] inv_round;
    logic        [13:0] inv_val;
    logic        [13:0] interp_val;

    assign diff = $signed({1'b0, src}) - $signed({1'b0, base});
    assign sum  = {1'b0, base} + {1'b0, src};

    always_comb
    begin
        case (mode)
            pbu_pkg::MODE_MULTIPLY:
            begin
                op_a = $signed({1'b0, base});
                op_b = src;
            end
            pbu_pkg::MODE_INVERT:
            begin
                op_a = $signed({1'b0, base});
                op_b = weight;
            end
            pbu_pkg::MODE_MORPH:
            begin
                op_a = diff;
                op_b = pbu_pkg::HALF_SCALE;
            end
            default:
            begin
                op_a = diff;
                op_b = weight;
            end
        endcase
    end

    assign prod = op_a * $signed({1'b0, op_b});

    // Divide by 4096 truncating toward zero
    assign quot       = prod[27] ? ((prod + 28'sd4095) >>> 12) : (prod >>> 12);
    assign interp_val = {1'b0, base} + quot[13:0];

    // ((4096-c)*g + c*(4096-g))/4096 = c + g - ceil(2*c*g/4096)
    assign inv_round = ({prod[24:0], 1'b0} + 26'd4095) >> 12;
    assign inv_val   = {1'b0, base} + {1'b0, weight} - inv_round[13:0];

    always_comb
    begin
        case (mode)
            pbu_pkg::MODE_ADD:
                result = (sum > {1'b0, pbu_pkg::FULL_SCALE}) ? pbu_pkg::FULL_SCALE : sum[12:0];
            pbu_pkg::MODE_SUBTRACT:
                result = (base < src) ? '0 : 13'(base - src);
            pbu_pkg::MODE_MULTIPLY:
                result = prod[24:12];
            pbu_pkg::MODE_BLEND:
                result = is_alpha ? base : interp_val[12:0];
            pbu_pkg::MODE_MORPH:
                result = interp_val[12:0];
            pbu_pkg::MODE_INVERT:
                result = is_alpha ? base : inv_val[12:0];
            pbu_pkg::MODE_MIN:
                result = (base < src) ? base : src;
            pbu_pkg::MODE_MAX:
                result = (base > src) ? base : src;
            pbu_pkg::MODE_IGNORE:
                result = base;
            default:
                result = src;
        endcase
    end

endmodule

// ===== tb/sv/pixel_blend_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the RGBA pixel blender.
// Stimulus enters on the s_axis side, results leave on m_axis, and the mode
// register is reached over APB. A local blend model predicts each output
// pixel not worked out by hand; a scoreboard queue matches results in order.
module pixel_blend_unit_tb;

    localparam int FULL = pbu_pkg::FULL_SCALE;
    localparam int HALF = pbu_pkg::HALF_SCALE;

    // Mode codes outside the defined set; the block treats them as replace
    localparam logic [pbu_pkg::MODE_W-1:0] MODE_UNUSED_LO = 4'd10;
    localparam logic [pbu_pkg::MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

    // Register index with nothing behind it; writes there must be dropped
    localparam logic REG_UNUSED = 1'b1;

    localparam int SEGMENTS     = 5;    // mode changes per idle phase
    localparam int SEG_ITEMS    = 100;  // pixels per mode segment
    localparam int HOLD_CYCLES  = 300;  // long m_tready hold-off
    localparam int DRAIN_CYCLES = 8;    // pipeline is two deep; some margin
    localparam int STALL_LIMIT  = 2000; // cycles with no transfer at all

    // One row of the directed table
    typedef struct {
        logic                           wr_cfg;
        logic                           cfg_index;
        logic [pbu_pkg::CFG_DATA_W-1:0] cfg_value;
        pbu_pkg::pixel_t                base_px;
        pbu_pkg::pixel_t                src_px;
        logic                           known_exp;  // expected pixel typed in below
        pbu_pkg::pixel_t                exp_px;
    } stim_row_t;

    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;

    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [pbu_pkg::CFG_ADDR_W-1:0]     paddr    = '0;
    logic [pbu_pkg::CFG_DATA_W-1:0]     pwdata   = '0;
    logic [pbu_pkg::CFG_DATA_W-1:0]     prdata;
    logic                               pready;

    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    // base_red, base_green, base_blue, base_alpha,
    // src_red, src_green, src_blue, src_alpha (13 bits each, red lowest)
    logic [pbu_pkg::IN_DATA_W-1:0]      s_tdata  = '0;

    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    // out_red, out_green, out_blue, out_alpha (13 bits each), 4 zero bits
    logic [pbu_pkg::OUT_DATA_W-1:0]     m_tdata;

    // Shadow of the mode register, updated on every accepted APB write to it
    logic [pbu_pkg::MODE_W-1:0]         cur_mode = pbu_pkg::MODE_REPLACE;

    pbu_pkg::pixel_t                    expected_pixels [$];
    stim_row_t                          directed_rows [$];

    int                                 errors        = 0;
    int                                 send_idle_pct = 0;
    int                                 recv_idle_pct = 0;
    logic                               hold_req      = 1'b0;

    pixel_blend_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Blend model
    // ------------------------------------------------------------------

    // Inputs above full scale count as full
    function automatic int clamp_full(input logic [pbu_pkg::CH_W-1:0] v);
        return (v > pbu_pkg::FULL_SCALE) ? FULL : int'(v);
    endfunction

    function automatic pbu_pkg::pixel_t blend_pixel(input logic [pbu_pkg::MODE_W-1:0] mode,
                                                    input pbu_pkg::pixel_t bp,
                                                    input pbu_pkg::pixel_t sp);
        int              b [4];
        int              s [4];
        int              r [4];
        pbu_pkg::pixel_t res;
        b[0] = clamp_full(bp.red);
        b[1] = clamp_full(bp.green);
        b[2] = clamp_full(bp.blue);
        b[3] = clamp_full(bp.alpha);
        s[0] = clamp_full(sp.red);
        s[1] = clamp_full(sp.green);
        s[2] = clamp_full(sp.blue);
        s[3] = clamp_full(sp.alpha);
        for (int i = 0; i < 4; i++)
        begin
            case (mode)
                pbu_pkg::MODE_ADD:
                    r[i] = (b[i] + s[i] > FULL) ? FULL : b[i] + s[i];
                pbu_pkg::MODE_SUBTRACT:
                    r[i] = (b[i] < s[i]) ? 0 : b[i] - s[i];
                pbu_pkg::MODE_MULTIPLY:
                    r[i] = (b[i] * s[i]) / FULL;
                // signed division truncates toward zero, as the block must
                pbu_pkg::MODE_BLEND:
                    r[i] = (i == 3) ? b[i] : b[i] + ((s[i] - b[i]) * s[3]) / FULL;
                pbu_pkg::MODE_MORPH:
                    r[i] = b[i] + ((s[i] - b[i]) * HALF) / FULL;
                pbu_pkg::MODE_INVERT:
                    r[i] = (i == 3) ? b[i]
                                    : ((FULL - b[i]) * s[3] + b[i] * (FULL - s[3])) / FULL;
                pbu_pkg::MODE_MIN:
                    r[i] = (b[i] < s[i]) ? b[i] : s[i];
                pbu_pkg::MODE_MAX:
                    r[i] = (b[i] > s[i]) ? b[i] : s[i];
                pbu_pkg::MODE_IGNORE:
                    r[i] = b[i];
                default:
                    r[i] = s[i];   // replace and the unused codes
            endcase
        end
        res.red   = r[0][pbu_pkg::CH_W-1:0];
        res.green = r[1][pbu_pkg::CH_W-1:0];
        res.blue  = r[2][pbu_pkg::CH_W-1:0];
        res.alpha = r[3][pbu_pkg::CH_W-1:0];
        return res;
    endfunction

    function automatic pbu_pkg::pixel_t pix(input int r, input int g, input int b,
                                            input int a);
        pbu_pkg::pixel_t p;
        p.red   = r[pbu_pkg::CH_W-1:0];
        p.green = g[pbu_pkg::CH_W-1:0];
        p.blue  = b[pbu_pkg::CH_W-1:0];
        p.alpha = a[pbu_pkg::CH_W-1:0];
        return p;
    endfunction

    // Mostly legal channel values, with a share of the extremes and of
    // out-of-range codes so every tdata bit toggles
    function automatic logic [pbu_pkg::CH_W-1:0] rand_ch();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            v = ($urandom_range(0, 1) != 0) ? FULL : 0;
        else if (pick < 25)
            v = $urandom_range(0, 8191);
        else
            v = $urandom_range(0, FULL);
        return v[pbu_pkg::CH_W-1:0];
    endfunction

    function automatic pbu_pkg::pixel_t rand_pixel();
        return pix(rand_ch(), rand_ch(), rand_ch(), rand_ch());
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic add_row(input logic wr_cfg, input logic idx,
                           input logic [pbu_pkg::CFG_DATA_W-1:0] value,
                           input pbu_pkg::pixel_t bp, input pbu_pkg::pixel_t sp,
                           input logic known_exp, input pbu_pkg::pixel_t ep);
        stim_row_t row;
        row.wr_cfg    = wr_cfg;
        row.cfg_index = idx;
        row.cfg_value = value;
        row.base_px   = bp;
        row.src_px    = sp;
        row.known_exp = known_exp;
        row.exp_px    = ep;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // Offer one pixel pair and wait for its transfer. Called just after a
    // rising edge; random idle cycles go in front of the offer.
    task automatic send_pixel(input pbu_pkg::pixel_t bp, input pbu_pkg::pixel_t sp,
                              input logic known_exp, input pbu_pkg::pixel_t ep);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {sp.alpha, sp.blue, sp.green, sp.red,
                     bp.alpha, bp.blue, bp.green, bp.red};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // transfer taken at this edge; the mode cannot change while busy
        if (known_exp)
            expected_pixels.push_back(ep);
        else
            expected_pixels.push_back(blend_pixel(cur_mode, bp, sp));
    endtask

    // Stop offering and let every pending result come out
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Register write with readback; only done with the pipeline empty
    task automatic write_config(input logic idx,
                                input logic [pbu_pkg::CFG_DATA_W-1:0] value);
        wait_drained();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == pbu_pkg::REG_BLEND_MODE)
            cur_mode = value[pbu_pkg::MODE_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= {pbu_pkg::REG_BLEND_MODE, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[pbu_pkg::MODE_W-1:0] !== cur_mode)
            report_mismatch("blend_mode readback", prdata[pbu_pkg::MODE_W-1:0], cur_mode);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, three random idle phases
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        pbu_pkg::pixel_t                none_px;
        logic [pbu_pkg::CFG_DATA_W-1:0] wr_value;
        int                             pick;

        none_px = pix(0, 0, 0, 0);

        // Directed table. Rows with known_exp set carry a hand-worked result.
        // Reset mode is replace; an out-of-range src channel saturates.
        add_row(1'b0, pbu_pkg::REG_BLEND_MODE, '0,
                pix(0, 0, 0, 0), pix(4096, 0, 8191, 123),
                1'b1, pix(4096, 0, 4096, 123));
        add_row(1'b0, pbu_pkg::REG_BLEND_MODE, '0,
                pix(8191, 8191, 8191, 8191), pix(0, 0, 0, 0),
                1'b1, pix(0, 0, 0, 0));
        // add saturates at full
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, pbu_pkg::MODE_ADD,
                pix(4096, 4096, 4096, 4096), pix(4096, 4096, 4096, 4096),
                1'b1, pix(4096, 4096, 4096, 4096));
        add_row(1'b0, pbu_pkg::REG_BLEND_MODE, '0,
                pix(100, 0, 8191, 4097), pix(200, 0, 1, 0),
                1'b1, pix(300, 0, 4096, 4096));
        // subtract clamps at zero
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, pbu_pkg::MODE_SUBTRACT,
                pix(0, 100, 4096, 4096), pix(4096, 50, 0, 8191),
                1'b1, pix(0, 50, 4096, 0));
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, pbu_pkg::MODE_MULTIPLY,
                pix(4096, 4096, 4096, 4096), pix(4096, 2048, 1, 0),
                1'b1, pix(4096, 2048, 1, 0));
        add_row(1'b0, pbu_pkg::REG_BLEND_MODE, '0,
                pix(1234, 4095, 3, 8000), pix(777, 4095, 4096, 5000),
                1'b0, none_px);
        // blend weight at both ends, then negative differences
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, pbu_pkg::MODE_BLEND,
                pix(10, 20, 30, 40), pix(500, 600, 700, 0),
                1'b1, pix(10, 20, 30, 40));
        add_row(1'b0, pbu_pkg::REG_BLEND_MODE, '0,
                pix(10, 20, 30, 40), pix(500, 600, 700, 4096),
                1'b1, pix(500, 600, 700, 40));
        add_row(1'b0, pbu_pkg::REG_BLEND_MODE, '0,
                pix(4000, 100, 2048, 7), pix(3, 4090, 2047, 3000),
                1'b0, none_px);
        // morph: odd negative steps exercise truncation toward zero
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, pbu_pkg::MODE_MORPH,
                pix(4096, 0, 1, 3), pix(0, 4096, 0, 0),
                1'b0, none_px);
        // invert at grade zero and full
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, pbu_pkg::MODE_INVERT,
                pix(0, 4096, 1000, 77), pix(9, 9, 9, 0),
                1'b1, pix(0, 4096, 1000, 77));
        add_row(1'b0, pbu_pkg::REG_BLEND_MODE, '0,
                pix(0, 4096, 1000, 77), pix(9, 9, 9, 4096),
                1'b1, pix(4096, 0, 3096, 77));
        add_row(1'b0, pbu_pkg::REG_BLEND_MODE, '0,
                pix(123, 4000, 2048, 8191), pix(1, 2, 3, 1000),
                1'b0, none_px);
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, pbu_pkg::MODE_MIN,
                pix(0, 4096, 8191, 5), pix(4096, 0, 4100, 6),
                1'b1, pix(0, 0, 4096, 5));
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, pbu_pkg::MODE_MAX,
                pix(0, 4096, 8191, 5), pix(4096, 0, 4100, 6),
                1'b1, pix(4096, 4096, 4096, 6));
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, pbu_pkg::MODE_IGNORE,
                pix(1, 2, 3, 4), pix(8191, 8191, 8191, 8191),
                1'b1, pix(1, 2, 3, 4));
        // unused mode codes fall back to replace
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, MODE_UNUSED_HI,
                pix(1, 2, 3, 4), pix(5, 6, 7, 8),
                1'b1, pix(5, 6, 7, 8));
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, MODE_UNUSED_LO,
                pix(1, 2, 3, 4), pix(5, 6, 7, 8),
                1'b1, pix(5, 6, 7, 8));
        // write to an unmapped index: mode must stay put
        add_row(1'b1, REG_UNUSED, pbu_pkg::MODE_ADD,
                pix(1, 2, 3, 4), pix(5, 6, 7, 8),
                1'b1, pix(5, 6, 7, 8));
        // upper pwdata bits are don't-care
        add_row(1'b1, pbu_pkg::REG_BLEND_MODE, {28'hFFF_FFFF, pbu_pkg::MODE_ADD},
                pix(4096, 1, 2, 3), pix(1, 1, 1, 1),
                1'b1, pix(4096, 2, 3, 4));

        send_idle_pct = 25;
        recv_idle_pct = 58;

        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].wr_cfg)
                write_config(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
            send_pixel(directed_rows[i].base_px, directed_rows[i].src_px,
                       directed_rows[i].known_exp, directed_rows[i].exp_px);
        end

        // Random part: phase 0 slow receiver, phase 1 slow sender, phase 2 flat out
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 58 : 0;
            recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 25 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    wr_value = $urandom();
                    write_config(REG_UNUSED, wr_value);
                end
                pick     = $urandom_range(0, 15);
                wr_value = $urandom();
                wr_value[pbu_pkg::MODE_W-1:0] = pick[pbu_pkg::MODE_W-1:0];
                write_config(pbu_pkg::REG_BLEND_MODE, wr_value);
                for (int n = 0; n < SEG_ITEMS; n++)
                begin
                    // sender waits out the whole pipeline once mid-segment
                    if (ph == 1 && seg == 2 && n == SEG_ITEMS / 2)
                        wait_drained();
                    // receiver goes quiet for a long stretch; input must back up
                    if (ph == 2 && seg == 1 && n == SEG_ITEMS / 2)
                        hold_req = 1'b1;
                    send_pixel(rand_pixel(), rand_pixel(), 1'b0, none_px);
                end
            end
        end

        wait_drained();
        if (errors == 0)
            $display("[pixel_blend_unit] OK");
        else
            $display("[pixel_blend_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // m_tready: random back-pressure, plus one long hold-off on request
    initial
    begin : result_ready
        logic hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Scoreboard: each result transfer is matched to the oldest prediction
    always @(posedge clk)
    begin : result_check
        pbu_pkg::pixel_t got;
        pbu_pkg::pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.red   = m_tdata[pbu_pkg::CH_W-1:0];
            got.green = m_tdata[2*pbu_pkg::CH_W-1:pbu_pkg::CH_W];
            got.blue  = m_tdata[3*pbu_pkg::CH_W-1:2*pbu_pkg::CH_W];
            got.alpha = m_tdata[4*pbu_pkg::CH_W-1:3*pbu_pkg::CH_W];
            if (expected_pixels.size() == 0)
                report_mismatch("result with none pending", 1, 0);
            else
            begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red)
                    report_mismatch("out_red", got.red, want.red);
                if (got.green !== want.green)
                    report_mismatch("out_green", got.green, want.green);
                if (got.blue !== want.blue)
                    report_mismatch("out_blue", got.blue, want.blue);
                if (got.alpha !== want.alpha)
                    report_mismatch("out_alpha", got.alpha, want.alpha);
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("[pixel_blend_unit] ERROR");
        $finish;
    end

endmodule

// ===== pixel_blend_unit.f =====
rtl/pbu_pkg.sv
rtl/pbu_cfg.sv
rtl/pbu_channel.sv
rtl/pixel_blend_unit.sv
tb/sv/pixel_blend_unit_tb.sv
